/* hw/rtl/ipv4hc_pkg.sv */
`default_nettype none
package ipv4hc_pkg;

    localparam int unsigned HDR_BYTES = 20;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned LEN_W     = 16;

    localparam logic [7:0]  VER_IHL    = 8'h45;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [15:0] SUM_GOOD   = 16'hffff;

    // verdict codes carried on the result channel
    typedef enum logic [3:0] {
        V_ICMP     = 4'd0,
        V_UDP      = 4'd1,
        V_VERSION  = 4'd2,
        V_FRAG     = 4'd3,
        V_TTL      = 4'd4,
        V_DEST     = 4'd5,
        V_CHECKSUM = 4'd6,
        V_PROTO    = 4'd7,
        V_LEARNED  = 4'd8,
        V_IGNORED  = 4'd9
    } verdict_t;

    // first early error found in the header
    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_VERSION = 2'd1,
        ERR_FRAG    = 2'd2,
        ERR_TTL     = 2'd3
    } err_t;

    // register index on the config port
    typedef enum logic {
        REG_ACCEPT_ADDR = 1'b0,
        REG_MAGIC_LEN   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [ADDR_W-1:0] accept_addr;
        logic [LEN_W-1:0]  magic_ping_len;
    } cfg_t;

    typedef struct packed {
        verdict_t verdict;
        logic     addr_known;
    } result_t;

endpackage
`default_nettype wire

/* hw/rtl/ipv4hc_regs.sv */
`default_nettype none
module ipv4hc_regs
    import ipv4hc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel;
    logic     wr_en;

    assign sel    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (sel)
                REG_ACCEPT_ADDR: cfg_next.accept_addr    = pwdata;
                REG_MAGIC_LEN:   cfg_next.magic_ping_len = pwdata[LEN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_ACCEPT_ADDR: prdata = cfg_reg.accept_addr;
            REG_MAGIC_LEN:   prdata = {{(32-LEN_W){1'b0}}, cfg_reg.magic_ping_len};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* hw/rtl/ipv4hc_check.sv */
`default_nettype none
module ipv4hc_check
    import ipv4hc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       hdr_byte,
    input  wire logic             first_byte,
    input  wire logic [LEN_W-1:0] frame_len,
    input  wire cfg_t             cfg,
    output logic                  res_valid,
    output result_t               res
);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]       sum_reg, sum_next;
    logic [7:0]        hi_reg, hi_next;
    err_t              err_reg, err_next;
    logic [7:0]        proto_reg, proto_next;
    logic [ADDR_W-1:0] dest_reg, dest_next;
    logic [ADDR_W-1:0] learned_reg, learned_next;

    // state as seen by this byte, after a restart
    logic [CNT_W-1:0] cnt_cur;
    logic [15:0]      sum_cur;
    logic [7:0]       hi_cur;
    err_t             err_cur;
    logic [15:0]      word;
    logic [CNT_W-1:0] cnt_inc;

    function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, w};
        ones_add = s[15:0] + {15'd0, s[16]};
    endfunction

    always_comb begin
        cnt_cur  = first_byte ? '0 : cnt_reg;
        sum_cur  = first_byte ? '0 : sum_reg;
        hi_cur   = first_byte ? '0 : hi_reg;
        err_cur  = first_byte ? ERR_NONE : err_reg;
        word     = {hi_cur, hdr_byte};
        cnt_inc  = cnt_cur + CNT_W'(1);

        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        hi_next      = hi_reg;
        err_next     = err_reg;
        proto_next   = proto_reg;
        dest_next    = dest_reg;
        learned_next = learned_reg;
        res_valid    = 1'b0;
        res.verdict  = V_IGNORED;
        res.addr_known = 1'b0;

        if (step) begin
            if (first_byte) begin
                cnt_next   = '0;
                sum_next   = '0;
                hi_next    = '0;
                err_next   = ERR_NONE;
                proto_next = '0;
                dest_next  = '0;
            end
            if (cnt_cur < CNT_W'(HDR_BYTES)) begin
                if (!cnt_cur[0]) begin
                    hi_next = hdr_byte;
                end else begin
                    sum_next = ones_add(sum_cur, word);
                    if (cnt_cur == CNT_W'(7) && err_cur == ERR_NONE && word[13:0] != '0)
                        err_next = ERR_FRAG;
                end
                if (cnt_cur == '0 && hdr_byte != VER_IHL)
                    err_next = ERR_VERSION;
                if (cnt_cur == CNT_W'(8) && err_cur == ERR_NONE && hdr_byte == '0)
                    err_next = ERR_TTL;
                if (cnt_cur == CNT_W'(9))
                    proto_next = hdr_byte;
                if (cnt_cur inside {[16:19]})
                    dest_next = {dest_next[ADDR_W-9:0], hdr_byte};
                cnt_next = cnt_inc;

                // last header byte: verdict from the updated state
                if (cnt_inc == CNT_W'(HDR_BYTES)) begin
                    res_valid = 1'b1;
                    case (err_next)
                        ERR_VERSION: res.verdict = V_VERSION;
                        ERR_FRAG:    res.verdict = V_FRAG;
                        ERR_TTL:     res.verdict = V_TTL;
                        default: begin
                            if (learned_reg != '0) begin
                                if (dest_next != cfg.accept_addr)
                                    res.verdict = V_DEST;
                                else if (sum_next != SUM_GOOD)
                                    res.verdict = V_CHECKSUM;
                                else if (proto_next == PROTO_ICMP)
                                    res.verdict = V_ICMP;
                                else if (proto_next == PROTO_UDP)
                                    res.verdict = V_UDP;
                                else
                                    res.verdict = V_PROTO;
                            end else if (proto_next == PROTO_ICMP
                                         && frame_len == cfg.magic_ping_len) begin
                                learned_next = dest_next;
                                res.verdict  = V_LEARNED;
                            end else begin
                                res.verdict = V_IGNORED;
                            end
                        end
                    endcase
                    res.addr_known = (learned_next != '0);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            sum_reg     <= '0;
            hi_reg      <= '0;
            err_reg     <= ERR_NONE;
            proto_reg   <= '0;
            dest_reg    <= '0;
            learned_reg <= '0;
        end else begin
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            hi_reg      <= hi_next;
            err_reg     <= err_next;
            proto_reg   <= proto_next;
            dest_reg    <= dest_next;
            learned_reg <= learned_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/ipv4_header_receive_check_unit.sv */
`default_nettype none
// ipv4 receive header check: takes a 20-byte ipv4 header one byte per transfer on
// the s_ stream (with the frame length and a first-byte flag) and gives one verdict
// transfer on the m_ stream after the twentieth byte; bytes after the verdict are
// dropped until the next first-byte flag. one byte is taken every cycle while the
// result side keeps up; a byte lands in the input register, the header check updates
// the counter, checksum and captured fields and the verdict lands in the result
// register, which drives m_tvalid. while a verdict waits with m_tready low the held
// byte waits too, and the input stalls until the verdict transfer. the apb port
// holds the accept address (0x0) and the magic ping length (0x4); write them only
// while no header is in flight
module ipv4_header_receive_check_unit
    import ipv4hc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] hdr_byte, [23:8] frame_len
    input  wire logic        s_tuser,   // [0] first_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [3:0] verdict, [4] addr_known, [7:5] zero
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t cfg;

    // input register
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic [LEN_W-1:0] in_len_reg;
    logic             in_first_reg;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    logic    advance;
    logic    res_valid;
    result_t res;

    ipv4hc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the held byte moves on whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ipv4hc_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .hdr_byte   (in_byte_reg),
        .first_byte (in_first_reg),
        .frame_len  (in_len_reg),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (advance && res_valid)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata[7:0];
            in_len_reg   <= s_tdata[23:8];
            in_first_reg <= s_tuser;
        end
        if (advance && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.addr_known, out_reg.verdict};

endmodule
`default_nettype wire
